// ===== rtl/ismc_pkg.sv =====
// Shared types, codes and sizes for the integer stack machine core.
package ismc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_VARS    = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int VA_W        = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int VC_W        = 9;

  // Byte address of the var_count register on the configuration port.
  localparam logic [1:0] CFG_VAR_COUNT_ADDR = 2'd0;

  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_XOR   = 4'd2,
    OP_NEG   = 4'd3,
    OP_ADD   = 4'd4,
    OP_SUB   = 4'd5,
    OP_MUL   = 4'd6,
    OP_DIV   = 4'd7,
    OP_REM   = 4'd8,
    OP_DUP   = 4'd9,
    OP_PUSH  = 4'd10,
    OP_STORE = 4'd11,
    OP_LOAD  = 4'd12,
    OP_NOP13 = 4'd13,
    OP_NOP14 = 4'd14,
    OP_NOP15 = 4'd15
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_INDEX = 3'd4,
    ST_RSV5  = 3'd5,
    ST_RSV6  = 3'd6,
    ST_RSV7  = 3'd7
  } status_t;

  typedef struct packed {
    logic [3:0]        action;
    logic signed [7:0] push_value;
    logic [7:0]        var_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        rem_sel;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage

// ===== rtl/ismc_div.sv =====
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
module ismc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ismc_pkg::div_req_t req,
  output ismc_pkg::div_rsp_t rsp
);
  import ismc_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic        qneg_r, rneg_r, rsel_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] shifted, diff;
  logic [31:0] a_mag, b_mag;

  assign a_mag = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
  assign b_mag = req.divisor[31]  ? (32'd0 - req.divisor)  : req.divisor;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    if (!diff[32]) begin
      rem_nxt = diff[31:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= a_mag;
      dvs_r  <= b_mag;
      qneg_r <= req.dividend[31] ^ req.divisor[31];
      rneg_r <= req.dividend[31];
      rsel_r <= req.rem_sel;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = rsel_r ? (rneg_r ? (32'd0 - rem_r) : rem_r)
                             : (qneg_r ? (32'd0 - quo_r) : quo_r);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'd32) else $error("divider count out of range");
  a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |=> cnt_r == $past(cnt_r) - 6'd1)
    else $error("divider count did not advance");

endmodule

// ===== rtl/integer_stack_machine_core.sv =====
// Top level of the integer stack machine core: control, operand stack and variable store.
//
// One input transfer on in_* carries one instruction; it produces exactly one
// result transfer on out_* with the top of stack, the depth and a status code.
// The top of stack lives in a register; the entries below it sit in a
// one-port synchronous memory, and the variables in a second memory.
// From the input transfer, an error or a no-op goes straight to the finish
// state; logic, add, subtract, negate, dup, push, load and store pass through
// the read and execute states; multiply adds a state as the product is
// registered, and divide or remainder wait for the 32 iterations of the radix-2 divider.
// in_stall is high from the input transfer until the result is placed in the
// output register, so one instruction is in flight at a time. The output
// register lets the next instruction be taken while a result waits; a stalled
// result holds until out_stall falls, and the core waits to finish the next
// instruction until then.
// Reset empties the stack, marks all variables as zero through per-entry
// valid bits and sets var_count to 256; no clearing pass is needed. var_count is
// to be written through the APB port at address 0 while idle; the core checks neither.
module integer_stack_machine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ismc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ismc_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import ismc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t          state_r;
  logic [SP_W-1:0] sp_r;
  logic [31:0]     tos_r;
  logic [VC_W-1:0] var_count_r;
  action_t         act_r;
  logic [31:0]     imm_r;
  logic [7:0]      idx_r;
  status_t         status_r, chk_status;
  logic            out_valid_r;
  out_item_t       out_r;
  logic [31:0]     prod_r;

  logic [31:0]     stk_mem [STACK_DEPTH];
  logic [31:0]     var_mem [MAX_VARS];
  logic [MAX_VARS-1:0] var_vld_r;
  logic [31:0]     stk_rdata_r, var_rdata_r;
  logic            var_vld_rd_r;

  logic            in_fire, fin_fire, cfg_wr;
  logic [31:0]     b_val, alu_res, load_val;
  logic [SA_W-1:0] top_addr, below_addr;
  logic [VA_W-1:0] vaddr;
  logic            idx_ok;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_VAR_COUNT_ADDR) ?
                      {{(32-VC_W){1'b0}}, var_count_r} : 32'd0;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign top_addr   = SA_W'(sp_r - SP_W'(1));
  assign below_addr = SA_W'(sp_r - SP_W'(2));
  assign vaddr      = VA_W'(idx_r);
  assign b_val      = stk_rdata_r;
  assign load_val   = var_vld_rd_r ? var_rdata_r : 32'd0;

  // Error checks in priority order: underflow, bad index, overflow, divide by zero.
  always_comb begin
    logic [3:0] a;
    logic       ok_idx;
    a      = in_data.action;
    ok_idx = (VC_W'(in_data.var_index) < var_count_r) &&
             (32'(in_data.var_index) < MAX_VARS);
    chk_status = ST_OK;
    if (a <= OP_REM && a != OP_NEG) begin
      if (sp_r < SP_W'(2))                          chk_status = ST_UNDER;
      else if ((a == OP_DIV || a == OP_REM) && tos_r == 32'd0) chk_status = ST_DIVZ;
    end else if (a == OP_NEG || a == OP_DUP) begin
      if (sp_r == '0)                               chk_status = ST_UNDER;
      else if (a == OP_DUP && sp_r >= SP_W'(STACK_DEPTH)) chk_status = ST_OVER;
    end else if (a == OP_PUSH) begin
      if (sp_r >= SP_W'(STACK_DEPTH))               chk_status = ST_OVER;
    end else if (a == OP_STORE) begin
      if (sp_r == '0)                               chk_status = ST_UNDER;
      else if (!ok_idx)                             chk_status = ST_INDEX;
    end else if (a == OP_LOAD) begin
      if (!ok_idx)                                  chk_status = ST_INDEX;
      else if (sp_r >= SP_W'(STACK_DEPTH))          chk_status = ST_OVER;
    end
  end
  assign idx_ok = (chk_status == ST_OK);

  always_comb begin
    case (act_r)
      OP_AND:  alu_res = b_val & tos_r;
      OP_OR:   alu_res = b_val | tos_r;
      OP_XOR:  alu_res = b_val ^ tos_r;
      OP_ADD:  alu_res = b_val + tos_r;
      OP_SUB:  alu_res = b_val - tos_r;
      default: alu_res = 32'd0 - tos_r;
    endcase
  end

  assign div_req.start    = (state_r == S_EXEC) && (act_r == OP_DIV || act_r == OP_REM);
  assign div_req.rem_sel  = (act_r == OP_REM);
  assign div_req.dividend = b_val;
  assign div_req.divisor  = tos_r;

  ismc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      tos_r       <= '0;
      var_count_r <= VC_W'(256);
      var_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        var_count_r <= cfg_pwdata[VC_W-1:0];
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r    <= action_t'(in_data.action);
            imm_r    <= 32'(in_data.push_value);
            idx_r    <= in_data.var_index;
            status_r <= chk_status;
            if (!idx_ok || in_data.action > OP_LOAD) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          case (act_r)
            OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB: begin
              tos_r   <= alu_res;
              sp_r    <= sp_r - SP_W'(1);
              state_r <= S_FIN;
            end
            OP_NEG: begin
              tos_r   <= alu_res;
              state_r <= S_FIN;
            end
            OP_MUL:  state_r <= S_MUL;
            OP_DIV, OP_REM: state_r <= S_DIV;
            OP_DUP: begin
              sp_r    <= sp_r + SP_W'(1);
              state_r <= S_FIN;
            end
            OP_PUSH: begin
              tos_r   <= imm_r;
              sp_r    <= sp_r + SP_W'(1);
              state_r <= S_FIN;
            end
            OP_LOAD: begin
              tos_r   <= load_val;
              sp_r    <= sp_r + SP_W'(1);
              state_r <= S_FIN;
            end
            OP_STORE: begin
              var_vld_r[vaddr] <= 1'b1;
              tos_r   <= (sp_r >= SP_W'(2)) ? b_val : 32'd0;
              sp_r    <= sp_r - SP_W'(1);
              state_r <= S_FIN;
            end
            default: state_r <= S_FIN;
          endcase
        end
        S_MUL: begin
          tos_r   <= prod_r;
          sp_r    <= sp_r - SP_W'(1);
          state_r <= S_FIN;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            tos_r   <= div_rsp.result;
            sp_r    <= sp_r - SP_W'(1);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Memories and payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      stk_rdata_r  <= stk_mem[below_addr];
      var_rdata_r  <= var_mem[vaddr];
      var_vld_rd_r <= var_vld_r[vaddr];
    end
    if (state_r == S_EXEC && sp_r != '0 &&
        (act_r == OP_DUP || act_r == OP_PUSH || act_r == OP_LOAD)) begin
      stk_mem[top_addr] <= tos_r;
    end
    if (state_r == S_EXEC && act_r == OP_STORE) begin
      var_mem[vaddr] <= tos_r;
    end
    if (state_r == S_EXEC) begin
      prod_r <= b_val * tos_r;
    end
    if (fin_fire) begin
      out_r.top_value   <= (sp_r == '0) ? 32'd0 : tos_r;
      out_r.stack_depth <= 7'(sp_r);
      out_r.status      <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_error_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (status_r != ST_OK) |-> sp_r == $past(sp_r))
    else $error("failed instruction changed the stack pointer");
  a_fin_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |-> !out_valid_r || !out_stall)
    else $error("result overwrote a pending transfer");
  a_div_only_divide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (act_r == OP_DIV || act_r == OP_REM))
    else $error("divider wait on a non-divide instruction");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the integer stack machine core.
`timescale 1ns / 100ps

module testbench;
  import ismc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_psel = 1'b0;
  logic       cfg_penable = 1'b0;
  logic       cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic       cfg_pready;

  integer_stack_machine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  // Shadow machine state.
  logic [31:0] shadow_stack [STACK_DEPTH];
  logic [31:0] shadow_vars [MAX_VARS];
  int          shadow_sp;
  int          shadow_var_count;

  in_item_t    instr_q [$];
  out_item_t   expected_q [$];
  int          errors = 0;
  int          gen_depth;
  int          gen_var_count;
  int          stall_pct = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  function automatic logic [31:0] alu(action_t op, logic [31:0] b, logic [31:0] a);
    logic signed [31:0] sb;
    logic signed [31:0] sa;
    sb = b;
    sa = a;
    case (op)
      OP_AND: return b & a;
      OP_OR:  return b | a;
      OP_XOR: return b ^ a;
      OP_ADD: return b + a;
      OP_SUB: return b - a;
      OP_MUL: return b * a;
      OP_DIV: begin
        if (b == 32'h8000_0000 && a == 32'hFFFF_FFFF) return b;
        return sb / sa;
      end
      default: begin
        if (b == 32'h8000_0000 && a == 32'hFFFF_FFFF) return '0;
        return sb % sa;
      end
    endcase
  endfunction

  task automatic execute_instr(in_item_t it);
    status_t   st;
    bit        idx_ok;
    out_item_t res;
    st = ST_OK;
    idx_ok = (it.var_index < shadow_var_count) && (it.var_index < MAX_VARS);
    case (action_t'(it.action))
      OP_NEG: begin
        if (shadow_sp < 1) st = ST_UNDER;
        else shadow_stack[shadow_sp-1] = 32'd0 - shadow_stack[shadow_sp-1];
      end
      OP_DUP: begin
        if (shadow_sp < 1) st = ST_UNDER;
        else if (shadow_sp >= STACK_DEPTH) st = ST_OVER;
        else begin
          shadow_stack[shadow_sp] = shadow_stack[shadow_sp-1];
          shadow_sp++;
        end
      end
      OP_PUSH: begin
        if (shadow_sp >= STACK_DEPTH) st = ST_OVER;
        else begin
          shadow_stack[shadow_sp] = {{24{it.push_value[7]}}, it.push_value};
          shadow_sp++;
        end
      end
      OP_STORE: begin
        if (shadow_sp < 1) st = ST_UNDER;
        else if (!idx_ok) st = ST_INDEX;
        else begin
          shadow_vars[it.var_index] = shadow_stack[shadow_sp-1];
          shadow_sp--;
        end
      end
      OP_LOAD: begin
        if (!idx_ok) st = ST_INDEX;
        else if (shadow_sp >= STACK_DEPTH) st = ST_OVER;
        else begin
          shadow_stack[shadow_sp] = shadow_vars[it.var_index];
          shadow_sp++;
        end
      end
      OP_NOP13, OP_NOP14, OP_NOP15: ;
      default: begin
        if (shadow_sp < 2) st = ST_UNDER;
        else if ((it.action == OP_DIV || it.action == OP_REM) &&
                 shadow_stack[shadow_sp-1] == 32'd0) st = ST_DIVZ;
        else begin
          shadow_stack[shadow_sp-2] = alu(action_t'(it.action),
                                          shadow_stack[shadow_sp-2],
                                          shadow_stack[shadow_sp-1]);
          shadow_sp--;
        end
      end
    endcase
    res.top_value   = (shadow_sp > 0) ? shadow_stack[shadow_sp-1] : 32'd0;
    res.stack_depth = shadow_sp[6:0];
    res.status      = st;
    expected_q.push_back(res);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (in_valid && !in_stall) execute_instr(in_data);
    if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (instr_q.size() > 0) begin
        in_data  <= instr_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(12);
          gap_left = (gap_max > 0) ? $urandom_range(gap_max) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives a random stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t want;
        want = expected_q.pop_front();
        if (out_data.top_value !== want.top_value ||
            out_data.stack_depth !== want.stack_depth ||
            out_data.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected top %0d depth %0d status %0d, got %0d %0d %0d",
                     want.top_value, want.stack_depth, want.status,
                     out_data.top_value, out_data.stack_depth, out_data.status);
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic add_instr(action_t op, int value, int idx);
    in_item_t it;
    it.action     = op;
    it.push_value = value[7:0];
    it.var_index  = idx[7:0];
    instr_q.push_back(it);
  endtask

  task automatic write_var_count(int value);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= CFG_VAR_COUNT_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow_var_count = value & 32'h1FF;
    gen_var_count = shadow_var_count;
  endtask

  // Mostly sensible programs steered by a rough depth estimate, plus noise.
  task automatic queue_program(int count, int push_pct);
    action_t op;
    int      r;
    int      idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      idx = (gen_var_count > 0 && $urandom_range(9) > 0) ?
            $urandom_range(((gen_var_count > 256) ? 256 : gen_var_count) - 1) :
            $urandom_range(255);
      if ($urandom_range(9) == 0) op = action_t'($urandom_range(15));
      else if (gen_depth < 2 || r < push_pct)
        op = ($urandom_range(3) == 0) ? OP_LOAD : OP_PUSH;
      else if (r < push_pct + 8) op = OP_STORE;
      else if (r < push_pct + 14) op = OP_DUP;
      else if (r < push_pct + 18) op = OP_NEG;
      else begin
        op = action_t'($urandom_range(8));
        if (op == OP_NEG) op = OP_SUB;
      end
      add_instr(op, $urandom_range(255), idx);
      case (op)
        OP_PUSH, OP_LOAD, OP_DUP: if (gen_depth < STACK_DEPTH) gen_depth++;
        OP_NEG, OP_NOP13, OP_NOP14, OP_NOP15: ;
        default: if (gen_depth > 0) gen_depth--;
      endcase
    end
  endtask

  task automatic drain();
    wait (instr_q.size() == 0 && !in_valid && expected_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    shadow_sp = 0;
    shadow_var_count = 256;
    gen_depth = 0;
    gen_var_count = 256;
    for (int i = 0; i < MAX_VARS; i++) shadow_vars[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_var_count(256);
    // Directed: no-ops, underflow on an empty stack, the most negative value
    // built by multiplication, its negation and division by minus one.
    add_instr(OP_NOP13, 0, 0);
    add_instr(OP_NOP14, 0, 0);
    add_instr(OP_NOP15, 0, 0);
    add_instr(OP_ADD, 0, 0);
    add_instr(OP_NEG, 0, 0);
    add_instr(OP_STORE, 0, 0);
    add_instr(OP_LOAD, 0, 255);
    add_instr(OP_PUSH, -128, 0);
    for (int i = 0; i < 4; i++) begin
      add_instr(OP_PUSH, 64, 0);
      add_instr(OP_MUL, 0, 0);
    end
    add_instr(OP_DUP, 0, 0);
    add_instr(OP_NEG, 0, 0);
    add_instr(OP_PUSH, -1, 0);
    add_instr(OP_DIV, 0, 0);
    add_instr(OP_DUP, 0, 0);
    add_instr(OP_PUSH, -1, 0);
    add_instr(OP_REM, 0, 0);
    add_instr(OP_DIV, 0, 0);
    add_instr(OP_PUSH, 127, 0);
    add_instr(OP_AND, 0, 0);
    add_instr(OP_PUSH, 127, 0);
    add_instr(OP_OR, 0, 0);
    add_instr(OP_PUSH, -128, 0);
    add_instr(OP_XOR, 0, 0);
    add_instr(OP_STORE, 0, 255);
    add_instr(OP_LOAD, 0, 255);
    add_instr(OP_SUB, 0, 0);
    gap_max = 3;
    drain();
    gen_depth = shadow_sp;

    stall_pct = 30; gap_max = 6;
    queue_program(60, 30);
    drain();

    write_var_count(0);
    stall_pct = 0; gap_max = 0;
    queue_program(40, 30);
    drain();

    // Deep stack: run into overflow.
    write_var_count(1);
    gen_depth = shadow_sp;
    stall_pct = 20; gap_max = 4;
    queue_program(90, 75);
    drain();

    write_var_count(17);
    gen_depth = shadow_sp;
    stall_pct = 60; gap_max = 10;
    queue_program(100, 25);
    drain();

    write_var_count(511);
    gen_depth = shadow_sp;
    stall_pct = 40; gap_max = 3;
    queue_program(80, 35);
    drain();

    write_var_count(255);
    gen_depth = shadow_sp;
    stall_pct = 0; gap_max = 0;
    queue_program(60, 30);
    drain();

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
